/* rtl/shpgc_pkg.sv */
`default_nettype none
package shpgc_pkg;

  // frame buffering limit, positions from here on are dropped
  localparam int MAX_FRAME_BYTES = 16384;
  // position counter must be able to hold MAX_FRAME_BYTES itself
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int HDR_W = 12;
  // compare width covers position, offset plus header size
  localparam int CMP_W = ((POS_W > HDR_W) ? POS_W : HDR_W) + 1;

  localparam int HEAP_W = 40;
  localparam int MISS_W = 48;
  localparam int CNT_W = 32;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [7:0] SPEAD_MAGIC = 8'd83;
  localparam logic [7:0] DEFAULT_OFFSET = 8'd42;
  localparam logic [CNT_W-1:0] DEFAULT_LIMIT = '1;

  // byte offsets inside the spead header
  localparam int HDR_LEN_POS = 7;
  localparam int HEAP_FIRST_POS = 11;
  localparam int HEAP_LAST_POS = 15;
  localparam int PAYLOAD_MIN_POS = 16;

  // register select, taken from paddr[2]
  localparam logic REG_HEADER_OFFSET = 1'b0;
  localparam logic REG_PACKET_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              payload_valid;
    logic              summary_valid;
    logic              frame_was_spead;
    logic [HEAP_W-1:0] heap_count;
    logic [HEAP_W-1:0] heap_gap;
    logic [CNT_W-1:0]  packets_counted;
    logic [HEAP_W-1:0] first_heap;
  } mid_t;

endpackage
`default_nettype wire

/* rtl/spead_header_parse_gap_count_core.sv */
// spead header parser with heap gap counting, one frame word per cycle while out_ready_i does not stall
// a word passes through the input register, the parse stage register and the output register
// throughput: 1 word per cycle while the output is not stalled, set by the single parse stage that owns frame state
// words that give no result (header bytes, non-spead bytes) leave no output
// reset: async active low, clears counters and frame state, offset 42, limit all ones
`default_nettype none
module spead_header_parse_gap_count_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input words
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        frame_byte_i,
  input  wire logic                              frame_end_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [7:0]                             payload_byte_o,
  output logic                                   payload_valid_o,
  output logic                                   summary_valid_o,
  output logic                                   frame_was_spead_o,
  output logic [shpgc_pkg::HEAP_W-1:0]           heap_count_o,
  output logic [shpgc_pkg::HEAP_W-1:0]           heap_gap_o,
  output logic [shpgc_pkg::MISS_W-1:0]           missed_total_o,
  output logic [shpgc_pkg::CNT_W-1:0]            packets_counted_o,
  output logic [shpgc_pkg::HEAP_W-1:0]           first_heap_o,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [shpgc_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [shpgc_pkg::DATA_W-1:0]      pwdata,
  output logic [shpgc_pkg::DATA_W-1:0]           prdata,
  output logic                                   pready
);

  localparam int MW = shpgc_pkg::MISS_W;

  // configuration registers
  logic [7:0]                  offset_q;
  logic [shpgc_pkg::CNT_W-1:0] limit_q;
  logic                        reg_wr;

  // input register stage
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       par_ready;

  // parse stage result
  logic            mid_valid;
  logic            mid_ready;
  shpgc_pkg::mid_t mid;

  // accumulate and output stage
  logic            out_v_q;
  shpgc_pkg::mid_t out_q;
  logic [MW-1:0]   out_missed_q;
  logic [MW-1:0]   missed_q, missed_d;
  logic [MW:0]     missed_sum;
  logic            mid_fire;

  //--------------------------------------------------------------------------
  // register port: always ready, register picked by paddr[2]
  //--------------------------------------------------------------------------
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      shpgc_pkg::REG_HEADER_OFFSET: prdata = shpgc_pkg::DATA_W'(offset_q);
      shpgc_pkg::REG_PACKET_LIMIT:  prdata = shpgc_pkg::DATA_W'(limit_q);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= shpgc_pkg::DEFAULT_OFFSET;
      limit_q  <= shpgc_pkg::DEFAULT_LIMIT;
    end else if (reg_wr) begin
      unique case (paddr[2])
        shpgc_pkg::REG_HEADER_OFFSET: offset_q <= pwdata[7:0];
        shpgc_pkg::REG_PACKET_LIMIT:  limit_q  <= pwdata[shpgc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // input register, refills whenever the parse stage drains it
  //--------------------------------------------------------------------------
  assign in_ready_o = !in_v_q || par_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= frame_byte_i;
      in_end_q  <= frame_end_i;
    end
  end

  //--------------------------------------------------------------------------
  // parse stage: frame position, magic, header size, heap counter, packet
  // count and gap; drops words that give no result
  //--------------------------------------------------------------------------
  shpgc_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_v_q),
    .in_ready_o      (par_ready),
    .byte_i          (in_byte_q),
    .end_i           (in_end_q),
    .header_offset_i (offset_q),
    .packet_limit_i  (limit_q),
    .mid_valid_o     (mid_valid),
    .mid_ready_i     (mid_ready),
    .mid_o           (mid)
  );

  //--------------------------------------------------------------------------
  // accumulate stage: saturating missed total, then the output register
  //--------------------------------------------------------------------------
  assign mid_ready = !out_v_q || out_ready_i;
  assign mid_fire  = mid_valid && mid_ready;

  always_comb begin
    missed_sum = {1'b0, missed_q} + (MW+1)'(mid.heap_gap);
    missed_d   = missed_q;
    if (mid.summary_valid) begin
      // carry out of the 48-bit sum means saturate
      missed_d = missed_sum[MW] ? {MW{1'b1}} : missed_sum[MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      missed_q <= '0;
    end else begin
      if (mid_ready) begin
        out_v_q <= mid_valid;
      end
      if (mid_fire) begin
        missed_q <= missed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_fire) begin
      out_q        <= mid;
      out_missed_q <= mid.summary_valid ? missed_d : '0;
    end
  end

  assign out_valid_o       = out_v_q;
  assign payload_byte_o    = out_q.payload_byte;
  assign payload_valid_o   = out_q.payload_valid;
  assign summary_valid_o   = out_q.summary_valid;
  assign frame_was_spead_o = out_q.frame_was_spead;
  assign heap_count_o      = out_q.heap_count;
  assign heap_gap_o        = out_q.heap_gap;
  assign missed_total_o    = out_missed_q;
  assign packets_counted_o = out_q.packets_counted;
  assign first_heap_o      = out_q.first_heap;

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  // every result word carries payload or a summary
  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_valid_o || summary_valid_o))
    else $error("result word with neither payload nor summary");

  // a counted frame only shows up on a summary, with a nonzero packet count
  a_spead_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_was_spead_o) |-> (summary_valid_o && packets_counted_o != '0))
    else $error("spead frame flagged without summary or count");

  // missed total never goes backwards
  a_missed_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> (missed_q >= $past(missed_q)))
    else $error("missed total decreased");

  // a gap is only reported for a counted frame
  a_gap_needs_spead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && heap_gap_o != '0) |-> frame_was_spead_o)
    else $error("heap gap on a frame that was not counted");

endmodule
`default_nettype wire

/* rtl/shpgc_parse.sv */
`default_nettype none
module shpgc_parse (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     byte_i,
  input  wire logic                           end_i,
  input  wire logic [7:0]                     header_offset_i,
  input  wire logic [shpgc_pkg::CNT_W-1:0]    packet_limit_i,
  output logic                                mid_valid_o,
  input  wire logic                           mid_ready_i,
  output shpgc_pkg::mid_t                     mid_o
);

  localparam int CW = shpgc_pkg::CMP_W;
  localparam int HW = shpgc_pkg::HEAP_W;

  logic [shpgc_pkg::POS_W-1:0] pos_q, pos_d;
  logic                        magic_q, magic_d;
  logic [shpgc_pkg::HDR_W-1:0] hdr_q, hdr_d;
  logic [HW-1:0]               heap_q, heap_d;
  logic [HW-1:0]               prev_q, prev_d;
  logic [shpgc_pkg::CNT_W-1:0] total_q, total_d;
  logic [HW-1:0]               first_q, first_d;
  logic                        mid_v_q;
  shpgc_pkg::mid_t             mid_q, mid_d;

  logic          fire, inrange, accept_ok, fwd, spead, has_gap;
  logic [CW-1:0] p_x, off_x;
  logic [HW:0]   prev_inc;
  logic [8:0]    len_inc;

  assign in_ready_o  = !mid_v_q || mid_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign mid_valid_o = mid_v_q;
  assign mid_o       = mid_q;

  always_comb begin
    p_x     = CW'(pos_q);
    off_x   = CW'(header_offset_i);
    inrange = p_x < CW'(shpgc_pkg::MAX_FRAME_BYTES);
    len_inc = {1'b0, byte_i} + 9'd1;

    magic_d = magic_q;
    hdr_d   = hdr_q;
    heap_d  = heap_q;
    if (inrange) begin
      if (p_x == off_x) begin
        magic_d = (byte_i == shpgc_pkg::SPEAD_MAGIC);
      end
      if (p_x == off_x + CW'(shpgc_pkg::HDR_LEN_POS)) begin
        hdr_d = {len_inc, 3'b000};
      end
      if (p_x >= off_x + CW'(shpgc_pkg::HEAP_FIRST_POS) &&
          p_x <= off_x + CW'(shpgc_pkg::HEAP_LAST_POS)) begin
        heap_d = {heap_q[HW-9:0], byte_i};
      end
    end

    accept_ok = magic_d && (total_q < packet_limit_i);
    fwd = inrange && accept_ok &&
          (p_x >= off_x + CW'(shpgc_pkg::PAYLOAD_MIN_POS)) &&
          (p_x >= off_x + CW'(hdr_d));
    spead = accept_ok && (p_x >= off_x + CW'(shpgc_pkg::HEAP_LAST_POS));

    // gap only after the first counted packet and on a jump of more than one
    prev_inc = {1'b0, prev_q} + (HW+1)'(1);
    has_gap  = (total_q != '0) && ({1'b0, heap_d} > prev_inc);

    mid_d = '0;
    if (fwd) begin
      mid_d.payload_byte  = byte_i;
      mid_d.payload_valid = 1'b1;
    end

    pos_d   = pos_q;
    prev_d  = prev_q;
    total_d = total_q;
    first_d = first_q;
    if (end_i) begin
      if (spead) begin
        prev_d  = heap_d;
        total_d = total_q + 1'b1;
        if (total_q == '0) begin
          first_d = heap_d;
        end
        mid_d.frame_was_spead = 1'b1;
        mid_d.heap_count      = heap_d;
        if (has_gap) begin
          mid_d.heap_gap = heap_d - prev_q - HW'(1);
        end
      end
      mid_d.summary_valid   = 1'b1;
      mid_d.packets_counted = total_d;
      mid_d.first_heap      = first_d;
      // frame state starts over
      pos_d   = '0;
      magic_d = 1'b0;
      hdr_d   = '0;
      heap_d  = '0;
    end else if (inrange) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      magic_q <= 1'b0;
      hdr_q   <= '0;
      heap_q  <= '0;
      prev_q  <= '0;
      total_q <= '0;
      first_q <= '0;
      mid_v_q <= 1'b0;
    end else begin
      if (fire) begin
        pos_q   <= pos_d;
        magic_q <= magic_d;
        hdr_q   <= hdr_d;
        heap_q  <= heap_d;
        prev_q  <= prev_d;
        total_q <= total_d;
        first_q <= first_d;
      end
      if (in_ready_o) begin
        mid_v_q <= fire && (fwd || end_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mid_q <= mid_d;
    end
  end

endmodule
`default_nettype wire
